>>> hdl/bsam_pkg.sv
package bsam_pkg;

   localparam int POS_W    = 16;
   localparam int DATA_W   = 8;
   localparam int SIZE_W   = 5;
   localparam int TOT_W    = 17;
   localparam int STRIDE_W = 2 * SIZE_W;
   localparam int CSR_W    = TOT_W;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = POS_W + TOT_W;

   // largest buffer the map handles, larger sizes are clamped to it
   localparam logic [TOT_W-1:0] MAX_BYTES = TOT_W'(65536);
   // numerator of the fixed-point reciprocal, one unit above the widest offset
   localparam logic [TOT_W-1:0] RECIP_NUM = TOT_W'(2 ** POS_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TYPE_SIZE   = 2'd0,
      REG_COMP_COUNT  = 2'd1,
      REG_TOTAL_BYTES = 2'd2,
      REG_DIRECTION   = 2'd3
   } csr_index_type;

   // derived mapping values; the user must keep them stable while items are in flight, the block does not enforce it
   typedef struct packed {
      logic             passthru;
      logic [TOT_W-1:0] total;
      logic [TOT_W-1:0] limit;
      logic [TOT_W-1:0] divisor;
      logic [TOT_W-1:0] factor;
      logic [TOT_W-1:0] recip;
   } map_cfg_type;

endpackage

>>> hdl/bsam_div.sv
module bsam_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bsam_pkg::TOT_W-1:0] dividend,
   input  logic [bsam_pkg::TOT_W-1:0] divisor,
   output logic                      done,
   output logic [bsam_pkg::TOT_W-1:0] quotient
);
   import bsam_pkg::*;

   logic [TOT_W-1:0] rem_ff, rem_in;
   logic [TOT_W-1:0] quo_ff, quo_in;
   logic [TOT_W-1:0] dsr_ff, dsr_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [TOT_W:0]   trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[TOT_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = TOT_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TOT_W-1:0];
            quo_in = {quo_ff[TOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(TOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/bsam_cfg.sv
module bsam_cfg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bsam_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsam_pkg::CSR_W-1:0]     csr_wdata,
   output logic                          busy,
   output bsam_pkg::map_cfg_type         cfg
);
   import bsam_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ECOUNT,
      S_RECIP,
      S_LIMIT
   } state_type;

   state_type         state_ff;
   logic [SIZE_W-1:0] type_size_ff;
   logic [SIZE_W-1:0] comp_count_ff;
   logic [TOT_W-1:0]  total_ff;
   logic              direction_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [TOT_W-1:0]  ecount_ff;
   logic              div_start_ff;
   map_cfg_type       cfg_ff;

   logic [STRIDE_W-1:0] stride_c;
   logic [TOT_W-1:0]  total_clamp;
   logic [TOT_W-1:0]  div_dividend;
   logic [TOT_W-1:0]  div_divisor;
   logic              div_done;
   logic [TOT_W-1:0]  div_quotient;
   logic [TOT_W+STRIDE_W-1:0] limit_prod;

   assign stride_c    = STRIDE_W'(type_size_ff) * STRIDE_W'(comp_count_ff);
   assign total_clamp = (total_ff > MAX_BYTES) ? MAX_BYTES : total_ff;
   assign limit_prod  = (TOT_W+STRIDE_W)'(ecount_ff) * (TOT_W+STRIDE_W)'(stride_ff);

   // first pass: element count, second pass: reciprocal of the divisor in use
   always_comb begin
      if (state_ff == S_ECOUNT) begin
         div_dividend = total_clamp;
         div_divisor  = TOT_W'(stride_c);
      end else begin
         div_dividend = RECIP_NUM;
         div_divisor  = direction_ff ? ecount_ff : TOT_W'(stride_ff);
      end
   end

   bsam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      stride_ff <= stride_c;
      if (reset) begin
         type_size_ff    <= SIZE_W'(4);
         comp_count_ff   <= SIZE_W'(1);
         total_ff        <= '0;
         direction_ff    <= 1'b0;
         state_ff        <= S_IDLE;
         div_start_ff    <= 1'b0;
         ecount_ff       <= '0;
         cfg_ff          <= '{passthru: 1'b1, default: '0};
      end else begin
         div_start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               REG_TYPE_SIZE:   type_size_ff  <= csr_wdata[SIZE_W-1:0];
               REG_COMP_COUNT:  comp_count_ff <= csr_wdata[SIZE_W-1:0];
               REG_TOTAL_BYTES: total_ff      <= csr_wdata[TOT_W-1:0];
               REG_DIRECTION:   direction_ff  <= csr_wdata[0];
            endcase
            state_ff     <= S_ECOUNT;
            div_start_ff <= 1'b1;
         end else begin
            unique case (state_ff)
               S_IDLE: begin
               end
               S_ECOUNT: begin
                  if (div_done && !div_start_ff) begin
                     ecount_ff    <= div_quotient;
                     state_ff     <= S_RECIP;
                     div_start_ff <= 1'b1;
                  end
               end
               S_RECIP: begin
                  if (div_done && !div_start_ff) begin
                     cfg_ff.recip <= div_quotient;
                     state_ff     <= S_LIMIT;
                  end
               end
               S_LIMIT: begin
                  cfg_ff.passthru <= (stride_ff <= STRIDE_W'(1)) || (ecount_ff == '0);
                  cfg_ff.total    <= total_clamp;
                  cfg_ff.limit    <= limit_prod[TOT_W-1:0];
                  cfg_ff.divisor  <= direction_ff ? ecount_ff : TOT_W'(stride_ff);
                  cfg_ff.factor   <= direction_ff ? TOT_W'(stride_ff) : ecount_ff;
                  state_ff        <= S_IDLE;
               end
            endcase
         end
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign cfg  = cfg_ff;

endmodule

>>> hdl/bsam_pipe.sv
module bsam_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [bsam_pkg::POS_W-1:0]  position,
   input  logic [bsam_pkg::DATA_W-1:0] data_byte,
   input  bsam_pkg::map_cfg_type       cfg,
   output logic                        out_valid,
   output logic [bsam_pkg::POS_W-1:0]  dest_position,
   output logic [bsam_pkg::DATA_W-1:0] data_out,
   output logic                        out_of_range
);
   import bsam_pkg::*;

   // valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1: range checks
   logic [POS_W-1:0]  p1_ff, p2_ff, p3_ff, p4_ff;
   logic [DATA_W-1:0] b1_ff, b2_ff, b3_ff, b4_ff;
   logic              oor1_ff, oor2_ff, oor3_ff, oor4_ff;
   logic              byp1_ff, byp2_ff, byp3_ff, byp4_ff;
   logic              oor1_in, byp1_in;

   // stage 2: reciprocal estimate of the quotient
   logic [PROD_W-1:0] est_prod;
   logic [POS_W-1:0]  q2_ff, q2_in;

   // stage 3: remainder of the estimate
   logic [PROD_W-1:0] back_prod;
   logic [PROD_W-1:0] diff;
   logic [POS_W-1:0]  q3_ff;
   logic [TOT_W-1:0]  r3_ff, r3_in;

   // stage 4: one correction step
   logic [POS_W-1:0]  q4_ff, q4_in;
   logic [TOT_W-1:0]  r4_ff, r4_in;

   // stage 5: recombine
   logic [2*TOT_W-1:0] comb_prod;
   logic [2*TOT_W-1:0] comb_sum;
   logic [POS_W-1:0]   dest_ff, dest_in;
   logic [DATA_W-1:0]  data_ff;
   logic               oor5_ff;

   assign oor1_in = ({1'b0, position} >= cfg.total);
   assign byp1_in = cfg.passthru || ({1'b0, position} >= cfg.limit);

   assign est_prod = PROD_W'(p1_ff) * PROD_W'(cfg.recip);
   assign q2_in    = est_prod[2*POS_W-1:POS_W];

   assign back_prod = PROD_W'(q2_ff) * PROD_W'(cfg.divisor);
   assign diff      = PROD_W'(p2_ff) - back_prod;
   assign r3_in     = diff[TOT_W-1:0];

   always_comb begin
      if (r3_ff >= cfg.divisor) begin
         q4_in = q3_ff + POS_W'(1);
         r4_in = r3_ff - cfg.divisor;
      end else begin
         q4_in = q3_ff;
         r4_in = r3_ff;
      end
   end

   assign comb_prod = (2*TOT_W)'(r4_ff) * (2*TOT_W)'(cfg.factor);
   assign comb_sum  = comb_prod + (2*TOT_W)'(q4_ff);

   always_comb begin
      if (oor4_ff) begin
         dest_in = '0;
      end else if (byp4_ff) begin
         dest_in = p4_ff;
      end else begin
         dest_in = comb_sum[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= position;
      b1_ff   <= data_byte;
      oor1_ff <= oor1_in;
      byp1_ff <= byp1_in;

      p2_ff   <= p1_ff;
      b2_ff   <= b1_ff;
      oor2_ff <= oor1_ff;
      byp2_ff <= byp1_ff;
      q2_ff   <= q2_in;

      p3_ff   <= p2_ff;
      b3_ff   <= b2_ff;
      oor3_ff <= oor2_ff;
      byp3_ff <= byp2_ff;
      q3_ff   <= q2_ff;
      r3_ff   <= r3_in;

      p4_ff   <= p3_ff;
      b4_ff   <= b3_ff;
      oor4_ff <= oor3_ff;
      byp4_ff <= byp3_ff;
      q4_ff   <= q4_in;
      r4_ff   <= r4_in;

      dest_ff <= dest_in;
      data_ff <= b4_ff;
      oor5_ff <= oor4_ff;
   end

   assign out_valid     = v5_ff;
   assign dest_position = dest_ff;
   assign data_out      = data_ff;
   assign out_of_range  = oor5_ff;

endmodule

>>> hdl/byte_shuffle_address_map.sv
// byte shuffle address map: for each byte offset of a buffer, gives the offset it moves to
// under the byte shuffle prefilter (direction 0) or its inverse (direction 1). a request is
// taken on any cycle with start high and busy low, one per cycle, and its result appears
// as a one-cycle rsp_valid strobe at the pipeline output; the receiver cannot hold it off,
// so nothing here ever stalls. every register write starts a recompute of the element
// count (total / stride) and of a fixed-point reciprocal of the active divisor on a
// one-bit-per-cycle divider; busy stays high until the recompute after the last write ends and no
// request is taken meanwhile. write registers only with no requests in flight.
// offsets at or beyond the buffer size come back flagged with a destination of zero
module byte_shuffle_address_map (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          start,
   output logic                          busy,
   input  logic [bsam_pkg::POS_W-1:0]    req_position,
   input  logic [bsam_pkg::DATA_W-1:0]   req_data_byte,
   // result side
   output logic                          rsp_valid,
   output logic [bsam_pkg::POS_W-1:0]    rsp_dest_position,
   output logic [bsam_pkg::DATA_W-1:0]   rsp_data_out,
   output logic                          rsp_out_of_range,
   // register write port
   input  logic                          csr_we,
   input  logic [bsam_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsam_pkg::CSR_W-1:0]    csr_wdata
);
   import bsam_pkg::*;

   map_cfg_type cfg;
   logic        req_take;

   // item enters the pipeline
   assign req_take = start && !busy;

   // register file plus the sequencer that derives element count, bounds and reciprocal
   bsam_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .cfg       (cfg)
   );

   // five-stage map: range checks, quotient estimate, remainder, correction, recombine
   bsam_pipe u_pipe (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_take),
      .position      (req_position),
      .data_byte     (req_data_byte),
      .cfg           (cfg),
      .out_valid     (rsp_valid),
      .dest_position (rsp_dest_position),
      .data_out      (rsp_data_out),
      .out_of_range  (rsp_out_of_range)
   );

   // each taken item comes out after the fixed pipeline latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##5 rsp_valid)
      else $error("item did not emerge after pipeline latency");

   // no result without a matching item taken into the pipeline
   a_no_ghost : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, 5))
      else $error("result strobe without a matching item");

   // a register write always launches the recompute
   a_write_busy : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("register write did not raise busy");

   // flagged offsets carry a zero destination
   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_dest_position == '0))
      else $error("out of range result with non-zero destination");

endmodule
